// ===== hdl/crng_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crng_pkg
// Types and constants of the combined multiplicative generator with shuffle
// table: moduli, Schrage factors, reciprocals and item formats.
// ----------------------------------------------------------------------------
package crng_pkg;

	localparam int WORD_W = 31;

	localparam logic [30:0] MOD1   = 31'd2147483563;
	localparam logic [30:0] MOD2   = 31'd2147483399;
	localparam logic [30:0] MOD1M1 = 31'd2147483562;
	localparam logic [15:0] MUL1   = 16'd40014;
	localparam logic [15:0] MUL2   = 16'd40692;
	localparam logic [15:0] QUO1   = 16'd53668;
	localparam logic [15:0] QUO2   = 16'd52774;
	localparam logic [13:0] REM1   = 14'd12211;
	localparam logic [13:0] REM2   = 14'd3791;
	localparam logic [31:0] SEED2_RESET = 32'd123456789;

	// floor(2^32 / quotient): quotient estimate is exact or one low
	localparam logic [16:0] RECIP1 = 17'((64'd1 << 32) / 64'(QUO1));
	localparam logic [16:0] RECIP2 = 17'((64'd1 << 32) / 64'(QUO2));

	// generator select
	localparam logic GEN1 = 1'b0;
	localparam logic GEN2 = 1'b1;

	typedef struct packed {
		logic signed [31:0] state_word;
	} crng_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] next_state_word;
		logic [WORD_W-1:0] sample;
	} crng_rsp_t;

	typedef struct packed {
		logic        valid;
		logic        gen;
		logic [31:0] w;
	} sch_req_t;

	typedef struct packed {
		logic              valid;
		logic              gen;
		logic [WORD_W-1:0] r;
	} sch_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/crng_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crng_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface crng_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/crng_schrage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crng_schrage
// Four-stage Schrage step r = mul*w - k*m (+m if negative), k = w / quo,
// for either generator; one request may enter every cycle.
// ----------------------------------------------------------------------------
module crng_schrage (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire crng_pkg::sch_req_t  req,
	output crng_pkg::sch_rsp_t       rsp
);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        gen_s1, gen_s2, gen_s3, gen_s4;
	logic [31:0] w_s1;
	logic [48:0] p_s1;
	logic [15:0] kest_s2;
	logic [17:0] diff_s2;
	logic [31:0] a_s3;
	logic [31:0] b_s3;
	logic [30:0] r_s4;

	logic [16:0] recip;
	logic [15:0] quo2;
	logic [32:0] kq;
	logic [15:0] quo3;
	logic [15:0] mul3;
	logic [13:0] rem3;
	logic        ge3;
	logic [16:0] k3;
	logic [15:0] lo3;
	logic [30:0] mod4;
	logic [32:0] t4;
	logic [32:0] t4_fix;

	assign recip = (req.gen == crng_pkg::GEN2) ? crng_pkg::RECIP2 : crng_pkg::RECIP1;
	assign quo2  = (gen_s1 == crng_pkg::GEN2) ? crng_pkg::QUO2 : crng_pkg::QUO1;
	assign kq    = 33'(p_s1[48:32]) * 33'(quo2);

	assign quo3 = (gen_s2 == crng_pkg::GEN2) ? crng_pkg::QUO2 : crng_pkg::QUO1;
	assign mul3 = (gen_s2 == crng_pkg::GEN2) ? crng_pkg::MUL2 : crng_pkg::MUL1;
	assign rem3 = (gen_s2 == crng_pkg::GEN2) ? crng_pkg::REM2 : crng_pkg::REM1;
	// estimate one low: fix quotient and remainder
	assign ge3  = diff_s2 >= 18'(quo3);
	assign k3   = 17'(kest_s2) + 17'(ge3);
	assign lo3  = ge3 ? 16'(diff_s2 - 18'(quo3)) : diff_s2[15:0];

	assign mod4   = (gen_s3 == crng_pkg::GEN2) ? crng_pkg::MOD2 : crng_pkg::MOD1;
	assign t4     = {1'b0, a_s3} - {1'b0, b_s3};
	assign t4_fix = t4[32] ? t4 + 33'(mod4) : t4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		gen_s1  <= req.gen;
		w_s1    <= req.w;
		p_s1    <= 49'(req.w) * 49'(recip);
		gen_s2  <= gen_s1;
		kest_s2 <= p_s1[47:32];
		diff_s2 <= 18'(w_s1 - kq[31:0]);
		gen_s3  <= gen_s2;
		a_s3    <= 32'(lo3) * 32'(mul3);
		b_s3    <= 32'(k3) * 32'(rem3);
		gen_s4  <= gen_s3;
		r_s4    <= t4_fix[30:0];
	end

	assign rsp.valid = v_s4;
	assign rsp.gen   = gen_s4;
	assign rsp.r     = r_s4;

endmodule
`default_nettype wire

// ===== hdl/crng_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crng_table
// Shuffle table: one write and one registered read port; entries never
// written since reset read as zero.
// ----------------------------------------------------------------------------
module crng_table #(
	parameter  int DEPTH = 32,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [crng_pkg::WORD_W-1:0] wdata,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               raddr,
	output logic      [crng_pkg::WORD_W-1:0] rdata
);

	logic [crng_pkg::WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]            vld_q;
	logic [crng_pkg::WORD_W-1:0] rd_q;
	logic                        rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

// ===== hdl/combined_lcg_shuffle_rng.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Two-generator multiplicative random generator with shuffle table.
// ----------------------------------------------------------------------------
// Usage:
//   req carries the caller's generator word; rsp returns the updated word
//   (to be sent with the next request) and the shuffled sample. Uniform value
//   is sample / 2147483563, scaling left to the consumer.
//   A word of zero or below reseeds with its magnitude (one for a zero word)
//   before drawing. One item at a time: a draw is accepted in idle, runs
//   through the Schrage pipeline and the table read-modify-write, and its
//   result is then registered in the output register; the next draw is only
//   accepted once the block is back in idle. A reseed adds TABLE_DEPTH+8
//   serial Schrage steps, each waiting for the four-stage step to finish,
//   plus a settle phase for the slot index pipeline.
//   The output register holds its result while the receiver stalls; the next
//   item is still accepted and waits in its last state for the register.
//   Reset: second word 123456789, last output zero, table reads all zero.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng #(
	parameter int TABLE_DEPTH = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	crng_stream_if.sink   req,
	crng_stream_if.source rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int JW = $clog2(TABLE_DEPTH + 8);
	localparam int SW = $clog2(TABLE_DEPTH) + 2;
	localparam logic [31:0] NDIV =
		32'(64'd1 + 64'(crng_pkg::MOD1M1) / 64'(TABLE_DEPTH));
	localparam logic [SW-1:0] RS = SW'((64'd1 << 32) / 64'(NDIV));

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WARM = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_RUN  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	localparam logic [2:0] PH_GEN1   = 3'd0;
	localparam logic [2:0] PH_GEN2   = 3'd1;
	localparam logic [2:0] PH_READ   = 3'd3;
	localparam logic [2:0] PH_WORD   = 3'd4;
	localparam logic [2:0] PH_LAST   = 3'd5;
	// slot pipeline catches up with a fresh last output; wraps to PH_GEN1
	localparam logic [2:0] PH_SETTLE = 3'd7;

	logic [2:0]              state_q;
	logic [2:0]              ph_q;
	logic [JW-1:0]           j_q;
	logic [31:0]             word_q;
	logic [31:0]             second_q;
	logic [30:0]             last_q;
	logic [30:0]             wnew_q;
	crng_pkg::crng_rsp_t     res_q;
	crng_pkg::crng_rsp_t     out_q;
	logic                    out_v_q;

	logic [31+SW-1:0]        sp_s1;
	logic [SW-1:0]           est_s2;
	logic [31:0]             diff_s2;
	logic [AW-1:0]           slot_s3;

	crng_pkg::sch_req_t      sch_req;
	crng_pkg::sch_rsp_t      sch_rsp;

	logic                    tbl_we;
	logic [AW-1:0]           tbl_waddr;
	logic [30:0]             tbl_wdata;
	logic                    tbl_re;
	logic [30:0]             tbl_rdata;

	logic signed [31:0]      in_word;
	logic [31:0]             mag;
	logic [31+SW-1:0]        prod2;
	logic [SW-1:0]           kf3;
	logic [32:0]             ldiff;
	logic [32:0]             lfix;
	logic                    accept;
	logic                    warm_store;

	// ---------------- Schrage unit ----------------
	always_comb begin
		sch_req.valid = (state_q == S_WARM) ||
			(state_q == S_RUN && (ph_q == PH_GEN1 || ph_q == PH_GEN2));
		sch_req.gen   = (state_q == S_RUN && ph_q == PH_GEN2) ? crng_pkg::GEN2
			: crng_pkg::GEN1;
		sch_req.w     = (sch_req.gen == crng_pkg::GEN2) ? second_q : word_q;
	end

	crng_schrage u_sch (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sch_req),
		.rsp    (sch_rsp)
	);

	// ---------------- slot = last / NDIV, saturated ----------------
	assign prod2 = (31+SW)'(est_s2) * (31+SW)'(NDIV);
	assign kf3   = est_s2 + SW'(diff_s2 >= NDIV);

	always_ff @(posedge clk) begin
		sp_s1   <= (31+SW)'(last_q) * (31+SW)'(RS);
		est_s2  <= SW'(sp_s1[31+SW-1:32]);
		diff_s2 <= {1'b0, last_q} - prod2[31:0];
		slot_s3 <= (kf3 >= SW'(TABLE_DEPTH)) ? AW'(TABLE_DEPTH - 1) : kf3[AW-1:0];
	end

	// ---------------- shuffle table ----------------
	assign warm_store = (state_q == S_WAIT) && sch_rsp.valid && (j_q < JW'(TABLE_DEPTH));
	assign tbl_we     = warm_store || (state_q == S_RUN && ph_q == PH_LAST);
	assign tbl_waddr  = warm_store ? j_q[AW-1:0] : slot_s3;
	assign tbl_wdata  = warm_store ? sch_rsp.r : wnew_q;
	assign tbl_re     = (state_q == S_RUN && ph_q == PH_READ);

	crng_table #(.DEPTH(TABLE_DEPTH)) u_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (tbl_we),
		.waddr  (tbl_waddr),
		.wdata  (tbl_wdata),
		.re     (tbl_re),
		.raddr  (slot_s3),
		.rdata  (tbl_rdata)
	);

	// ---------------- sequencer ----------------
	assign in_word = req.data.state_word;
	assign mag     = (in_word == 32'sd0) ? 32'd1 : 32'(-in_word);
	assign accept  = req.valid && req.ready;
	// table entry minus second word, lifted into range
	assign ldiff   = {2'b00, tbl_rdata} - {2'b00, sch_rsp.r};
	assign lfix    = ($signed(ldiff) < 33'sd1) ? ldiff + 33'(crng_pkg::MOD1M1) : ldiff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ph_q     <= PH_GEN1;
			j_q      <= '0;
			second_q <= crng_pkg::SEED2_RESET;
			last_q   <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_v_q || rsp.ready)) begin
				out_v_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ph_q <= PH_GEN1;
						if (in_word <= 32'sd0) begin
							word_q   <= mag;
							second_q <= mag;
							j_q      <= JW'(TABLE_DEPTH + 7);
							state_q  <= S_WARM;
						end else begin
							word_q  <= 32'(in_word);
							state_q <= S_RUN;
						end
					end
				end
				S_WARM: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (sch_rsp.valid) begin
						word_q <= {1'b0, sch_rsp.r};
						if (j_q == '0) begin
							last_q  <= sch_rsp.r;
							ph_q    <= PH_SETTLE;
							state_q <= S_RUN;
						end else begin
							j_q     <= j_q - JW'(1);
							state_q <= S_WARM;
						end
					end
				end
				S_RUN: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == PH_WORD) begin
						wnew_q <= sch_rsp.r;
					end
					if (ph_q == PH_LAST) begin
						second_q              <= {1'b0, sch_rsp.r};
						last_q                <= lfix[30:0];
						res_q.next_state_word <= wnew_q;
						res_q.sample          <= lfix[30:0];
						state_q               <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_v_q || rsp.ready) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	// ---------------- assertions ----------------
	a_word_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN && ph_q == PH_WORD |-> sch_rsp.valid && sch_rsp.gen == crng_pkg::GEN1)
		else $error("first generator word missing in draw");

	a_second_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN && ph_q == PH_LAST |-> sch_rsp.valid && sch_rsp.gen == crng_pkg::GEN2)
		else $error("second generator word missing in draw");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we && tbl_re |-> tbl_waddr != slot_s3)
		else $error("table read and write hit the same entry");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN && ph_q == PH_LAST |=> last_q != '0)
		else $error("last output out of range after draw");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for combined_lcg_shuffle_rng. A scoreboard model of the
// two Schrage generators and the shuffle table predicts each draw. Directed
// words cover reset state, range edges, reseeds and one long output stall.
// Random streams of reseed-then-chain requests, stray words and broken chains
// follow, with idle bursts on both channels, then chains with no idle bursts.
// ----------------------------------------------------------------------------
module testbench;

	localparam int     TB_DEPTH     = 32;
	localparam longint SLOT_DIV     = 1 + longint'(crng_pkg::MOD1M1) / TB_DEPTH;
	localparam int     LIMIT_CYCLES = 1000000;
	localparam int     HOLD_CYCLES  = 300;
	localparam int     RANDOM_ITEMS = 780;
	localparam int     TOTAL_ITEMS  = 900;

	logic clk;
	logic arst_n;

	crng_stream_if #(.T(crng_pkg::crng_req_t)) req_ch ();
	crng_stream_if #(.T(crng_pkg::crng_rsp_t)) rsp_ch ();

	combined_lcg_shuffle_rng #(
		.TABLE_DEPTH(TB_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// scoreboard copy of the generator state
	longint seed2_word;
	longint last_sample;
	longint shuffle_tab [TB_DEPTH];

	crng_pkg::crng_rsp_t pending_draws [$];
	crng_pkg::crng_rsp_t oldest_draw;
	logic [30:0]         carry_word;
	int                  items_sent;
	int                  fail_count;
	int                  cycle_count;
	bit                  idle_on;
	bit                  hold_results;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint schrage_step(input longint w, input logic gen);
		longint k;
		longint r;
		if (gen == crng_pkg::GEN1) begin
			k = w / longint'(crng_pkg::QUO1);
			r = longint'(crng_pkg::MUL1) * (w - k * longint'(crng_pkg::QUO1))
				- longint'(crng_pkg::REM1) * k;
			if (r < 0)
				r += longint'(crng_pkg::MOD1);
		end else begin
			k = w / longint'(crng_pkg::QUO2);
			r = longint'(crng_pkg::MUL2) * (w - k * longint'(crng_pkg::QUO2))
				- longint'(crng_pkg::REM2) * k;
			if (r < 0)
				r += longint'(crng_pkg::MOD2);
		end
		return r;
	endfunction

	function automatic void reset_generator();
		seed2_word  = longint'(crng_pkg::SEED2_RESET);
		last_sample = 0;
		foreach (shuffle_tab[i])
			shuffle_tab[i] = 0;
	endfunction

	// advances the model by one request and returns the draw it yields
	function automatic crng_pkg::crng_rsp_t predict_draw(input logic signed [31:0] word_in);
		longint              w;
		longint              slot;
		crng_pkg::crng_rsp_t d;
		w = longint'(word_in);
		if (w <= 0) begin
			w = -w;
			if (w < 1)
				w = 1;
			seed2_word = w;
			for (int j = TB_DEPTH + 7; j >= 0; j--) begin
				w = schrage_step(w, crng_pkg::GEN1);
				if (j < TB_DEPTH)
					shuffle_tab[j] = w;
			end
			last_sample = shuffle_tab[0];
		end
		w          = schrage_step(w, crng_pkg::GEN1);
		seed2_word = schrage_step(seed2_word, crng_pkg::GEN2);
		slot = last_sample / SLOT_DIV;
		if (slot < 0)
			slot = 0;
		if (slot >= TB_DEPTH)
			slot = TB_DEPTH - 1;
		last_sample       = shuffle_tab[slot] - seed2_word;
		shuffle_tab[slot] = w;
		if (last_sample < 1)
			last_sample += longint'(crng_pkg::MOD1M1);
		d.next_state_word = w[30:0];
		d.sample          = last_sample[30:0];
		return d;
	endfunction

	task automatic send_word(input logic signed [31:0] w);
		crng_pkg::crng_rsp_t d;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.data.state_word <= w;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		d = predict_draw(w);
		carry_word = d.next_state_word;
		pending_draws.push_back(d);
		items_sent++;
	endtask

	// caller behaviour: hand back the word from the last draw
	task automatic send_chain(input int n);
		for (int i = 0; i < n; i++)
			send_word(signed'({1'b0, carry_word}));
	endtask

	// stops offering items, then waits for every outstanding result
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_draws.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_reset_state();
		send_word(32'sd12345);
		send_word(32'sd2147483562);
		send_word(32'sd1);
	endtask

	task automatic test_word_extremes();
		send_word(32'sd2147483647);
		// multiple of the first modulus: first word collapses to zero
		send_word(32'sd2147483563);
		send_word(32'sd0);
		send_chain(2);
	endtask

	task automatic test_reseed_words();
		send_word(-32'sd1);
		send_chain(2);
		send_word(32'h8000_0000);
		send_chain(3);
		send_word(-32'sd2147483647);
		send_chain(2);
		send_word(-$signed({1'b0, 31'($urandom)}));
		send_chain(1);
	endtask

	task automatic test_output_stall();
		wait_drained();
		idle_on      = 1'b0;
		hold_results = 1'b1;
		send_word(-$signed({1'b0, 31'($urandom)}));
		send_chain(11);
		wait_drained();
		while (hold_results)
			@(posedge clk);
	endtask

	task automatic test_random_streams(input int target);
		int kind;
		int n;
		while (items_sent < target) begin
			kind    = $urandom_range(0, 9);
			idle_on = ($urandom_range(0, 3) != 0);
			n       = $urandom_range(4, 25);
			if (kind <= 6) begin
				if ($urandom_range(0, 3) == 0)
					send_word(-$signed(32'($urandom_range(0, 1000))));
				else
					send_word({1'b1, 31'($urandom)});
				send_chain(n);
			end else if (kind <= 8) begin
				repeat ($urandom_range(1, 4))
					send_word($signed($urandom));
			end else begin
				// chain broken by stray words
				send_word({1'b1, 31'($urandom)});
				repeat (n) begin
					if ($urandom_range(0, 4) == 0)
						send_word(signed'({1'b0, 31'($urandom)}));
					else
						send_chain(1);
				end
			end
		end
	endtask

	task automatic test_full_rate(input int target);
		idle_on = 1'b0;
		while (items_sent < target) begin
			send_word({1'b1, 31'($urandom)});
			send_chain($urandom_range(10, 30));
		end
	endtask

	// result channel ready
	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				rsp_ch.ready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++)
					@(posedge clk);
				hold_results = 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_draws.size() == 0) begin
				$error("unexpected item: next_state_word %0d sample %0d",
					rsp_ch.data.next_state_word, rsp_ch.data.sample);
				fail_count++;
			end else begin
				oldest_draw = pending_draws.pop_front();
				if (rsp_ch.data.next_state_word !== oldest_draw.next_state_word) begin
					$error("next_state_word: expected %0d, got %0d",
						oldest_draw.next_state_word, rsp_ch.data.next_state_word);
					fail_count++;
				end
				if (rsp_ch.data.sample !== oldest_draw.sample) begin
					$error("sample: expected %0d, got %0d",
						oldest_draw.sample, rsp_ch.data.sample);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		items_sent             = 0;
		fail_count             = 0;
		cycle_count            = 0;
		idle_on                = 1'b1;
		hold_results           = 1'b0;
		carry_word             = '0;
		req_ch.valid          <= 1'b0;
		req_ch.data           <= '0;
		arst_n                 = 1'b0;
		reset_generator();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_word_extremes();
		test_reseed_words();
		test_output_stall();
		test_random_streams(RANDOM_ITEMS);
		test_full_rate(TOTAL_ITEMS);

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== combined_lcg_shuffle_rng.f =====
hdl/crng_pkg.sv
hdl/crng_stream_if.sv
hdl/crng_schrage.sv
hdl/crng_table.sv
hdl/combined_lcg_shuffle_rng.sv
tb/testbench.sv
